FILE: sv/msec_pkg.sv
// Shared opcodes, function codes, status codes and stage structs of the execute core.
`timescale 1ns / 1ps

package msec_pkg;

	// Primary opcodes
	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_J     = 6'h02;
	localparam logic [5:0] OP_JAL   = 6'h03;
	localparam logic [5:0] OP_BEQ   = 6'h04;
	localparam logic [5:0] OP_BNE   = 6'h05;
	localparam logic [5:0] OP_BLT   = 6'h06;
	localparam logic [5:0] OP_BGE   = 6'h07;
	localparam logic [5:0] OP_ADDI  = 6'h08;
	localparam logic [5:0] OP_SLTI  = 6'h0A;
	localparam logic [5:0] OP_ANDI  = 6'h0C;
	localparam logic [5:0] OP_ORI   = 6'h0D;
	localparam logic [5:0] OP_LW    = 6'h23;
	localparam logic [5:0] OP_LBU   = 6'h24;
	localparam logic [5:0] OP_SB    = 6'h28;
	localparam logic [5:0] OP_SW    = 6'h2B;

	// R-type function codes
	localparam logic [5:0] FN_SLL     = 6'h00;
	localparam logic [5:0] FN_MUL     = 6'h01;
	localparam logic [5:0] FN_SRL     = 6'h02;
	localparam logic [5:0] FN_JR      = 6'h08;
	localparam logic [5:0] FN_SYSCALL = 6'h0C;
	localparam logic [5:0] FN_ADD     = 6'h20;
	localparam logic [5:0] FN_SUB     = 6'h22;
	localparam logic [5:0] FN_AND     = 6'h24;
	localparam logic [5:0] FN_OR      = 6'h25;
	localparam logic [5:0] FN_NOR     = 6'h27;
	localparam logic [5:0] FN_SLT     = 6'h2A;

	// Syscall service codes found in v0
	localparam logic [31:0] SC_PRINT_INT  = 32'd1;
	localparam logic [31:0] SC_PRINT_STR  = 32'd4;
	localparam logic [31:0] SC_READ_INT   = 32'd5;
	localparam logic [31:0] SC_READ_STR   = 32'd8;
	localparam logic [31:0] SC_EXIT       = 32'd10;
	localparam logic [31:0] SC_PRINT_CHAR = 32'd11;
	localparam logic [31:0] SC_READ_CHAR  = 32'd12;
	localparam logic [31:0] SC_EXIT_CODE  = 32'd17;

	// Architectural register numbers with a fixed role
	localparam logic [4:0] REG_ZERO = 5'd0;
	localparam logic [4:0] REG_V0   = 5'd2;
	localparam logic [4:0] REG_A0   = 5'd4;
	localparam logic [4:0] REG_SP   = 5'd29;
	localparam logic [4:0] REG_RA   = 5'd31;

	typedef enum logic [1:0] {
		ST_OK,
		ST_BAD_OP,
		ST_BAD_ADDR,
		ST_BAD_SYSCALL
	} status_t;

	// Everything the execute logic decides for one instruction
	typedef struct packed {
		logic [31:0] next_pc;
		logic        halt_next;
		status_t     status;
		logic        we;
		logic [4:0]  widx;
		logic [31:0] wdata;
		logic        is_load;
		logic        byte_op;
		logic        mem_wr;
		logic [31:0] addr;
		logic [31:0] st_data;
		logic        sys_req;
		logic [31:0] sys_code;
		logic [31:0] sys_arg;
	} exec_res_t;

	// Data memory access request
	typedef struct packed {
		logic        wr;
		logic        byte_op;
		logic [31:0] addr;
		logic [31:0] wdata;
	} dmem_req_t;

endpackage

FILE: sv/mips_subset_execute_core.sv
// Top level: instruction stream in, one execute result per instruction out.
// The instruction and its operands are registered at accept, then its result in stage 2.
// Throughput: one instruction per clock unless m_tready is low with a result held; the previous
// result, loads included, is bypassed from the result register, so dependent code never stalls.
// Reset: clears pc, halt flag, register file (sp reads MEM_BYTES) through per-entry
// valid bits at once; no clearing pass; data memory content is undefined until written.
`timescale 1ns / 1ps

module mips_subset_execute_core #(
	parameter int MEM_BYTES = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // [31:0] instr_word
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata    // next_pc, halted, status, reg_write_valid,
	                                // reg_write_index, reg_write_data, syscall_request,
	                                // syscall_code, syscall_arg, zero pad (low bit up)
);
	import msec_pkg::*;

	// Handshake and stage control
	logic        valid_s1;
	logic        valid_s2;
	logic        advance;
	logic        in_acc;
	logic        commit;

	// Architectural state
	logic [31:0] pc_q;
	logic        halt_q;
	logic [31:0] rf_valid_q;
	logic [31:0] v0_q;
	logic [31:0] a0_q;
	logic [31:0] rf_mem [32];

	// Stage 1: instruction and registered operand reads
	logic [31:0] instr_s1;
	logic [31:0] rs_mem_s1;
	logic [31:0] rt_mem_s1;
	logic        rs_alt_s1;
	logic        rt_alt_s1;
	logic [31:0] rs_altv_s1;
	logic [31:0] rt_altv_s1;

	// Stage 2: result register, also the pending register write
	logic [31:0] npc_s2;
	logic        halted_s2;
	status_t     status_s2;
	logic        we_s2;
	logic [4:0]  widx_s2;
	logic [31:0] wdata_s2;
	logic        is_load_s2;
	logic        sreq_s2;
	logic [31:0] scode_s2;
	logic [31:0] sarg_s2;

	logic [4:0]  rs_in;
	logic [4:0]  rt_in;
	logic [4:0]  rs_s1;
	logic [4:0]  rt_s1;
	logic [31:0] pend_val;
	logic [31:0] ld_data;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [31:0] v0_cur;
	logic [31:0] a0_cur;
	logic        rs_fwd;
	logic        rt_fwd;
	exec_res_t   res;
	dmem_req_t   dreq;

	function automatic logic [31:0] rf_reset_val(input logic [4:0] idx);
		return (idx == REG_SP) ? 32'(MEM_BYTES) : 32'd0;
	endfunction

	// Flow control: stage 1 moves on when the result register is free or drains
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign in_acc   = s_tvalid && s_tready;

	// Pending write of the previous instruction lands as the next one moves on
	assign pend_val = is_load_s2 ? ld_data : wdata_s2;
	assign commit   = advance && we_s2;

	assign rs_in = s_tdata[25:21];
	assign rt_in = s_tdata[20:16];
	assign rs_s1 = instr_s1[25:21];
	assign rt_s1 = instr_s1[20:16];

	// Operand read path: write-through on the commit edge, reset value if never written
	assign rs_fwd = commit && (widx_s2 == rs_in);
	assign rt_fwd = commit && (widx_s2 == rt_in);

	always_ff @(posedge clk) begin
		if (commit)
			rf_mem[widx_s2] <= pend_val;
		if (in_acc) begin
			rs_mem_s1 <= rf_mem[rs_in];
			rt_mem_s1 <= rf_mem[rt_in];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			instr_s1   <= s_tdata;
			rs_alt_s1  <= rs_fwd || !rf_valid_q[rs_in];
			rt_alt_s1  <= rt_fwd || !rf_valid_q[rt_in];
			rs_altv_s1 <= rs_fwd ? pend_val : rf_reset_val(rs_in);
			rt_altv_s1 <= rt_fwd ? pend_val : rf_reset_val(rt_in);
		end
	end

	// Bypass from the uncommitted previous instruction
	always_comb begin
		op_a   = rs_alt_s1 ? rs_altv_s1 : rs_mem_s1;
		op_b   = rt_alt_s1 ? rt_altv_s1 : rt_mem_s1;
		v0_cur = v0_q;
		a0_cur = a0_q;
		if (we_s2 && (widx_s2 == rs_s1))
			op_a = pend_val;
		if (we_s2 && (widx_s2 == rt_s1))
			op_b = pend_val;
		if (we_s2 && (widx_s2 == REG_V0))
			v0_cur = pend_val;
		if (we_s2 && (widx_s2 == REG_A0))
			a0_cur = pend_val;
	end

	msec_exec #(
		.MEM_BYTES (MEM_BYTES)
	) u_exec (
		.instr (instr_s1),
		.pc    (pc_q),
		.halt  (halt_q),
		.op_a  (op_a),
		.op_b  (op_b),
		.v0    (v0_cur),
		.a0    (a0_cur),
		.res   (res)
	);

	// Memory access is issued as the instruction leaves stage 1
	always_comb begin
		dreq         = '0;
		dreq.wr      = advance && res.mem_wr;
		dreq.byte_op = res.byte_op;
		dreq.addr    = res.addr;
		dreq.wdata   = res.st_data;
	end

	msec_dmem #(
		.MEM_BYTES (MEM_BYTES)
	) u_dmem (
		.clk     (clk),
		.rd_en   (advance),
		.req     (dreq),
		.ld_data (ld_data)
	);

	// Stage valids, architectural state and register file bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			we_s2      <= 1'b0;
			pc_q       <= '0;
			halt_q     <= 1'b0;
			rf_valid_q <= '0;
			v0_q       <= '0;
			a0_q       <= '0;
		end else begin
			if (in_acc)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;

			if (advance)
				valid_s2 <= 1'b1;
			else if (m_tready)
				valid_s2 <= 1'b0;

			if (advance) begin
				we_s2  <= res.we;
				pc_q   <= res.next_pc;
				halt_q <= res.halt_next;
			end

			if (commit) begin
				rf_valid_q[widx_s2] <= 1'b1;
				if (widx_s2 == REG_V0)
					v0_q <= pend_val;
				if (widx_s2 == REG_A0)
					a0_q <= pend_val;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			npc_s2     <= res.next_pc;
			halted_s2  <= res.halt_next;
			status_s2  <= res.status;
			widx_s2    <= res.widx;
			wdata_s2   <= res.wdata;
			is_load_s2 <= res.is_load;
			sreq_s2    <= res.sys_req;
			scode_s2   <= res.sys_code;
			sarg_s2    <= res.sys_arg;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'b0, sarg_s2, scode_s2, sreq_s2, pend_val, widx_s2, we_s2,
		status_s2, halted_s2, npc_s2};

endmodule

FILE: sv/msec_exec.sv
// Combinational decode and execute of one instruction: ALU, branch, range and syscall checks.
`timescale 1ns / 1ps

module msec_exec #(
	parameter int MEM_BYTES = 4096
) (
	input  logic                 [31:0] instr,
	input  logic                 [31:0] pc,
	input  logic                        halt,
	input  logic                 [31:0] op_a,
	input  logic                 [31:0] op_b,
	input  logic                 [31:0] v0,
	input  logic                 [31:0] a0,
	output msec_pkg::exec_res_t         res
);
	import msec_pkg::*;

	logic [5:0]  op;
	logic [4:0]  rt_idx;
	logic [4:0]  rd_idx;
	logic [4:0]  sh;
	logic [5:0]  fn;
	logic [15:0] imm;
	logic [31:0] simm;
	logic [31:0] zimm;
	logic [31:0] addr;
	logic [31:0] boff;
	logic [31:0] jtarget;
	logic        word_oob;
	logic        byte_oob;
	logic        b_lt_a;

	assign op      = instr[31:26];
	assign rt_idx  = instr[20:16];
	assign rd_idx  = instr[15:11];
	assign sh      = instr[10:6];
	assign fn      = instr[5:0];
	assign imm     = instr[15:0];
	assign simm    = {{16{imm[15]}}, imm};
	assign zimm    = {16'b0, imm};
	assign addr    = op_a + simm;
	assign boff    = {simm[29:0], 2'b00};
	assign jtarget = {6'b0, instr[25:0]};
	assign b_lt_a  = $signed(op_b) < $signed(op_a);

	// Range checks on the whole access, carried in 33 bits
	assign word_oob = ({1'b0, addr} + 33'd3) >= 33'(MEM_BYTES);
	assign byte_oob = {1'b0, addr} >= 33'(MEM_BYTES);

	always_comb begin
		logic        we_c;
		logic [4:0]  widx_c;
		logic [31:0] wval;
		logic        load_c;
		logic        byte_c;
		logic        store_c;
		logic [31:0] npc;
		status_t     st;
		logic        halt_n;
		logic        sreq;
		logic [31:0] scode;
		logic [31:0] sarg;

		we_c    = 1'b0;
		widx_c  = rd_idx;
		wval    = '0;
		load_c  = 1'b0;
		byte_c  = 1'b0;
		store_c = 1'b0;
		npc     = pc + 32'd4;
		st      = ST_OK;
		halt_n  = halt;
		sreq    = 1'b0;
		scode   = '0;
		sarg    = '0;

		if (halt) begin
			npc = pc;
		end else begin
			unique case (op)
				OP_RTYPE: begin
					unique case (fn)
						FN_SLL: begin we_c = 1'b1; wval = op_b << sh; end
						FN_MUL: begin we_c = 1'b1; wval = op_a * op_b; end
						FN_SRL: begin we_c = 1'b1; wval = op_b >> sh; end
						FN_JR:  npc = op_a;
						FN_SYSCALL: begin
							scode = v0;
							sarg  = a0;
							unique case (v0)
								SC_EXIT, SC_EXIT_CODE: halt_n = 1'b1;
								SC_PRINT_INT, SC_PRINT_STR, SC_READ_INT,
								SC_READ_STR, SC_PRINT_CHAR, SC_READ_CHAR: sreq = 1'b1;
								default: st = ST_BAD_SYSCALL;
							endcase
						end
						FN_ADD: begin we_c = 1'b1; wval = op_a + op_b; end
						FN_SUB: begin we_c = 1'b1; wval = op_a - op_b; end
						FN_AND: begin we_c = 1'b1; wval = op_a & op_b; end
						FN_OR:  begin we_c = 1'b1; wval = op_a | op_b; end
						FN_NOR: begin we_c = 1'b1; wval = ~(op_a | op_b); end
						FN_SLT: begin
							we_c = 1'b1;
							wval = {31'b0, $signed(op_a) < $signed(op_b)};
						end
						default: st = ST_BAD_OP;
					endcase
				end
				OP_J: npc = jtarget;
				OP_JAL: begin
					we_c   = 1'b1;
					widx_c = REG_RA;
					wval   = pc + 32'd8;
					npc    = jtarget;
				end
				OP_BEQ: if (op_a == op_b) npc = pc + boff;
				OP_BNE: if (op_a != op_b) npc = pc + boff;
				OP_BLT: if (b_lt_a) npc = pc + boff;
				OP_BGE: if (!b_lt_a) npc = pc + boff;
				OP_ADDI: begin we_c = 1'b1; widx_c = rt_idx; wval = op_a + simm; end
				OP_SLTI: begin
					we_c   = 1'b1;
					widx_c = rt_idx;
					wval   = {31'b0, $signed(op_a) < $signed(simm)};
				end
				OP_ANDI: begin we_c = 1'b1; widx_c = rt_idx; wval = op_a & zimm; end
				OP_ORI:  begin we_c = 1'b1; widx_c = rt_idx; wval = op_a | zimm; end
				OP_LW: begin
					if (word_oob) begin
						st = ST_BAD_ADDR;
					end else begin
						we_c   = 1'b1;
						widx_c = rt_idx;
						load_c = 1'b1;
					end
				end
				OP_LBU: begin
					byte_c = 1'b1;
					if (byte_oob) begin
						st = ST_BAD_ADDR;
					end else begin
						we_c   = 1'b1;
						widx_c = rt_idx;
						load_c = 1'b1;
					end
				end
				OP_SB: begin
					byte_c = 1'b1;
					if (byte_oob) st = ST_BAD_ADDR;
					else store_c = 1'b1;
				end
				OP_SW: begin
					if (word_oob) st = ST_BAD_ADDR;
					else store_c = 1'b1;
				end
				default: st = ST_BAD_OP;
			endcase
		end

		// r0 stays zero: a write to it is dropped and not reported
		res           = '0;
		res.next_pc   = npc;
		res.halt_next = halt_n;
		res.status    = st;
		res.we        = we_c && (widx_c != REG_ZERO);
		res.widx      = res.we ? widx_c : REG_ZERO;
		res.wdata     = (res.we && !load_c) ? wval : '0;
		res.is_load   = res.we && load_c;
		res.byte_op   = byte_c;
		res.mem_wr    = store_c;
		res.addr      = addr;
		res.st_data   = op_b;
		res.sys_req   = sreq;
		res.sys_code  = scode;
		res.sys_arg   = sarg;
	end

endmodule

FILE: sv/msec_dmem.sv
// Byte data memory in four interleaved banks, unaligned little-endian word and byte access.
`timescale 1ns / 1ps

module msec_dmem #(
	parameter int MEM_BYTES = 4096
) (
	input  logic                        clk,
	input  logic                        rd_en,
	input  msec_pkg::dmem_req_t         req,
	output logic                 [31:0] ld_data
);
	import msec_pkg::*;

	localparam int ROWS  = (MEM_BYTES + 3) / 4;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic [1:0]       lo;
	logic [ROW_W-1:0] row0;
	logic [ROW_W-1:0] row1;
	logic [1:0]       lo_q;
	logic             byte_q;
	logic [7:0]       rbyte [4];

	// Byte k of an access sits in bank (addr + k) mod 4, one row up when it wraps
	assign lo   = req.addr[1:0];
	assign row0 = req.addr[ROW_W+1:2];
	assign row1 = row0 + ROW_W'(1);

	for (genvar gb = 0; gb < 4; gb++) begin : g_bank
		logic [7:0]       bank_mem [ROWS];
		logic [7:0]       rd_q;
		logic [ROW_W-1:0] row;
		logic [1:0]       k;
		logic [7:0]       wbyte;
		logic             wen;

		assign k     = 2'(gb) - lo;
		assign row   = (2'(gb) < lo) ? row1 : row0;
		assign wbyte = req.wdata[{k, 3'b000} +: 8];
		assign wen   = req.wr && (!req.byte_op || (2'(gb) == lo));

		always_ff @(posedge clk) begin
			if (wen)
				bank_mem[row] <= wbyte;
			if (rd_en)
				rd_q <= bank_mem[row];
		end

		assign rbyte[gb] = rd_q;
	end

	// Alignment of the registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			lo_q   <= lo;
			byte_q <= req.byte_op;
		end
	end

	// Rotate the banks back into byte order
	assign ld_data = byte_q ? {24'b0, rbyte[lo_q]} :
		{rbyte[lo_q + 2'd3], rbyte[lo_q + 2'd2], rbyte[lo_q + 2'd1], rbyte[lo_q]};

endmodule

FILE: sv/msec_checker.sv
// Port-level checks on the result stream of the execute core, bound to the top level.
`timescale 1ns / 1ps

module msec_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [143:0] m_tdata
);
	import msec_pkg::*;

	// A stalled result holds still
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A halted core reports status ok
	a_halt_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[32] |-> m_tdata[34:33] == ST_OK)
		else $error("halted result with error status");

	// No register write means empty write fields; a write never targets r0
	a_wr_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[35] ? (m_tdata[40:36] != REG_ZERO) : (m_tdata[72:36] == '0)))
		else $error("inconsistent register write fields");

	// A service request is a clean syscall: no error, no register write, no halt
	a_sreq: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[73] |-> m_tdata[34:33] == ST_OK && !m_tdata[35] && !m_tdata[32])
		else $error("syscall request with error, write or halt");

endmodule

bind mips_subset_execute_core msec_checker u_msec_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
